@@ hdl/att_pkg.sv @@
// Package with payload types, constants and the arctangent table for the tilt angle block.
`timescale 1ns / 1ps
package att_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } att_in_t;

    typedef struct packed {
        logic signed [7:0] tilt_x_deg;
        logic signed [7:0] tilt_y_deg;
        logic        [7:0] tilt_z_deg;
    } att_out_t;

    localparam int AngFrac   = 16;
    localparam int MagFrac   = 14;
    localparam int TableLen  = 24;
    localparam int SqW       = 33;
    localparam int RootW     = 31;
    localparam int CordW     = 34;
    localparam int AccW      = 25;
    localparam int HalfTurn  = 180;
    localparam logic signed [AccW-1:0] AngLim = AccW'(90 << AngFrac);

    typedef struct packed {
        logic              neg_x;
        logic              neg_y;
        logic              neg_z;
    } att_sign_t;

    function automatic logic [22:0] atan_tab(input logic [4:0] idx);
        logic [22:0] v;
        unique case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/accel_tilt_angles.sv @@
// Top level: three tilt angles of an acceleration sample through root and CORDIC pipelines.
// Path: magnitudes, squares, root pipeline, CORDIC input, CORDIC stages (at most 24), output.
// Throughput: one sample per cycle; the whole pipeline advances when the output register
// is free or being emptied, and holds otherwise.
// Reset: synchronous active-low aresetn clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module accel_tilt_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  att_pkg::att_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output att_pkg::att_out_t m_data
);
    import att_pkg::*;

    localparam int NS  = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
    localparam int LAT = 2 + RootW + 1 + NS;

    logic            en;
    logic [LAT-1:0]  vld_reg;
    att_sign_t       sgn_reg [LAT];
    logic [15:0]     ax_reg, ay_reg, az_reg;
    logic [SqW-1:0]  sx_reg, sy_reg, sz_reg;
    logic [15:0]     mx_reg [RootW+1];
    logic [15:0]     my_reg [RootW+1];
    logic [15:0]     mz_reg [RootW+1];
    logic [RootW-1:0] r_yz, r_xz, r_xy;
    logic signed [AccW-1:0] ang_x, ang_y, ang_z;
    logic            out_valid_reg;
    att_out_t        out_reg, out_next;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[LAT-2:0], s_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg     <= mag16(s_data.accel_x);
            ay_reg     <= mag16(s_data.accel_y);
            az_reg     <= mag16(s_data.accel_z);
            sgn_reg[0] <= '{neg_x: s_data.accel_x[15], neg_y: s_data.accel_y[15],
                            neg_z: s_data.accel_z[15]};
            for (int k = 1; k < LAT; k++) sgn_reg[k] <= sgn_reg[k-1];
            sx_reg <= SqW'(ay_reg) * SqW'(ay_reg) + SqW'(az_reg) * SqW'(az_reg);
            sy_reg <= SqW'(ax_reg) * SqW'(ax_reg) + SqW'(az_reg) * SqW'(az_reg);
            sz_reg <= SqW'(ax_reg) * SqW'(ax_reg) + SqW'(ay_reg) * SqW'(ay_reg);
            mx_reg[0] <= ax_reg;
            my_reg[0] <= ay_reg;
            mz_reg[0] <= az_reg;
            for (int k = 1; k <= RootW; k++) begin
                mx_reg[k] <= mx_reg[k-1];
                my_reg[k] <= my_reg[k-1];
                mz_reg[k] <= mz_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    att_sqrt u_sqrt_x (.aclk(aclk), .en(en), .sq_in(sx_reg), .root_out(r_yz));
    att_sqrt u_sqrt_y (.aclk(aclk), .en(en), .sq_in(sy_reg), .root_out(r_xz));
    att_sqrt u_sqrt_z (.aclk(aclk), .en(en), .sq_in(sz_reg), .root_out(r_xy));

    att_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cord_x (
        .aclk(aclk), .en(en), .den(r_yz),
        .num({1'b0, mx_reg[RootW], {MagFrac{1'b0}}}), .angle(ang_x));
    att_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cord_y (
        .aclk(aclk), .en(en), .den(r_xz),
        .num({1'b0, my_reg[RootW], {MagFrac{1'b0}}}), .angle(ang_y));
    att_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cord_z (
        .aclk(aclk), .en(en), .den({1'b0, mz_reg[RootW], {MagFrac{1'b0}}}),
        .num(r_xy), .angle(ang_z));

    always_comb begin
        logic [7:0] dx, dy;
        logic signed [AccW-1:0] zt;
        att_sign_t sg;
        sg = sgn_reg[LAT-1];
        dx = 8'(ang_x >>> AngFrac);
        dy = 8'(ang_y >>> AngFrac);
        zt = sg.neg_z ? (AccW'(HalfTurn << AngFrac) - ang_z) : ang_z;
        out_next.tilt_x_deg = sg.neg_x ? -dx : dx;
        out_next.tilt_y_deg = sg.neg_y ? -dy : dy;
        out_next.tilt_z_deg = 8'(zt >>> AngFrac);
    end

    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");
    ap_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    ap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tilt_z_deg <= 8'd180 && m_data.tilt_x_deg <= 8'sd90
                     && m_data.tilt_x_deg >= -8'sd90))
        else $error("angle out of range");
endmodule

@@ hdl/att_sqrt.sv @@
// Pipelined restoring square root, one result bit per stage.
`timescale 1ns / 1ps
module att_sqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [att_pkg::SqW-1:0]    sq_in,
    output logic [att_pkg::RootW-1:0]  root_out
);
    import att_pkg::*;

    // The radicand is sq_in * 2^28; root has 31 bits, one bit resolved per stage.
    localparam int NW = SqW + 2 * MagFrac + 1;
    localparam int RW = RootW + 2;

    logic [NW-1:0] rem_reg  [RootW+1];
    logic [RW-1:0] part_reg [RootW+1];
    logic [NW-1:0] n_reg    [RootW+1];

    always_comb begin
        rem_reg[0]  = '0;
        part_reg[0] = '0;
        n_reg[0]    = {1'b0, sq_in, {(2*MagFrac){1'b0}}};
    end

    for (genvar k = 0; k < RootW; k++) begin : g_st
        logic [NW:0] trial;
        logic [NW:0] rem_sh;
        always_comb begin
            rem_sh = {rem_reg[k][NW-2:0], n_reg[k][NW-1 -: 2]};
            trial  = rem_sh - {{(NW+1-RW-2){1'b0}}, part_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k+1] <= {n_reg[k][NW-3:0], 2'b00};
                if (!trial[NW]) begin
                    rem_reg[k+1]  <= trial[NW-1:0];
                    part_reg[k+1] <= {part_reg[k][RW-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_sh[NW-1:0];
                    part_reg[k+1] <= {part_reg[k][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign root_out = part_reg[RootW][RootW-1:0];
endmodule

@@ hdl/att_cordic.sv @@
// Pipelined CORDIC vectoring unit giving an angle in degrees with 16 fraction bits.
`timescale 1ns / 1ps
module att_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [att_pkg::RootW-1:0]          den,
    input  logic [att_pkg::RootW-1:0]          num,
    output logic signed [att_pkg::AccW-1:0]    angle
);
    import att_pkg::*;

    localparam int NS = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;

    logic signed [CordW-1:0] x_reg   [NS+1];
    logic signed [CordW-1:0] y_reg   [NS+1];
    logic signed [AccW-1:0]  acc_reg [NS+1];
    logic [1:0]              sp_reg  [NS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CordW'(den);
            y_reg[0]   <= CordW'(num);
            acc_reg[0] <= '0;
            sp_reg[0]  <= {num == '0, den == '0};
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_st
        logic signed [CordW-1:0] xs;
        logic signed [CordW-1:0] ys;
        logic signed [AccW-1:0]  t;
        always_comb begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            t  = AccW'(atan_tab(5'(i)));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sp_reg[i+1] <= sp_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1]   <= x_reg[i] + ys;
                    y_reg[i+1]   <= y_reg[i] - xs;
                    acc_reg[i+1] <= acc_reg[i] + t;
                end else begin
                    x_reg[i+1]   <= x_reg[i] - ys;
                    y_reg[i+1]   <= y_reg[i] + xs;
                    acc_reg[i+1] <= acc_reg[i] - t;
                end
            end
        end
    end

    always_comb begin
        if (sp_reg[NS][1])
            angle = '0;
        else if (sp_reg[NS][0])
            angle = AngLim;
        else if (acc_reg[NS] < 0)
            angle = '0;
        else if (acc_reg[NS] > AngLim)
            angle = AngLim;
        else
            angle = acc_reg[NS];
    end
endmodule

@@ verif/tb_accel_tilt_angles.sv @@
// Testbench for the tilt angle block: directed table and random samples checked by a predictor.
`timescale 1ns / 1ps
module tb_accel_tilt_angles;
    import att_pkg::*;

    localparam int Stages     = 16;
    localparam int Latency    = 2 + 31 + Stages + 2;
    localparam int WdogLimit  = 20000;
    localparam int NumRandom  = 1830;
    localparam int HoldCycles = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    att_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    att_out_t m_data;

    att_out_t angle_queue[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_cnt = 0;
    bit stim_done = 1'b0;
    bit hold_req = 1'b0;
    bit no_gaps = 1'b0;

    typedef struct {
        att_in_t  sample;
        bit       known;
        att_out_t angles;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{8'sd0, 8'sd0, 8'd0}},
        '{'{16'sd0, 16'sd0, 16'sd100}, 1'b1, '{8'sd0, 8'sd0, 8'd0}},
        '{'{16'sd0, 16'sd0, -16'sd100}, 1'b1, '{8'sd0, 8'sd0, 8'd180}},
        '{'{16'sd1000, 16'sd0, 16'sd0}, 1'b1, '{8'sd90, 8'sd0, 8'd90}},
        '{'{-16'sd1000, 16'sd0, 16'sd0}, 1'b1, '{-8'sd90, 8'sd0, 8'd90}},
        '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b1, '{8'sd0, 8'sd90, 8'd90}},
        '{'{16'sd0, -16'sd32768, 16'sd0}, 1'b1, '{8'sd0, -8'sd90, 8'd90}},
        '{'{16'sd0, 16'sd0, -16'sd32768}, 1'b1, '{8'sd0, 8'sd0, 8'd180}},
        '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b1, '{8'sd0, 8'sd0, 8'd0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
        '{'{-16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0},
        '{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
        '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, '0},
        '{'{16'sd1, 16'sd0, 16'sd32767}, 1'b0, '0},
        '{'{16'sd32767, 16'sd1, -16'sd1}, 1'b0, '0},
        '{'{16'sd100, 16'sd100, 16'sd0}, 1'b0, '0},
        '{'{-16'sd16384, 16'sd16384, 16'sd0}, 1'b0, '0},
        '{'{16'sd1000, 16'sd1000, -16'sd1000}, 1'b0, '0},
        '{'{16'sd5, -16'sd7, 16'sd3}, 1'b0, '0}
    };

    always #2 aclk = ~aclk;

    accel_tilt_angles #(.CORDIC_STAGES(Stages)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned hypot_fix(input longint unsigned a,
                                                  input longint unsigned b);
        return int_root((a * a + b * b) << (2 * MagFrac));
    endfunction

    function automatic longint cordic_angle(input longint unsigned den,
                                            input longint unsigned num);
        longint cx, cy, acc, xs, ys, lim;
        longint steps [0:23];
        steps = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                  14668, 7334, 3667, 1833, 917, 458, 229, 115,
                  57, 29, 14, 7, 4, 2, 1, 0};
        cx = den;
        cy = num;
        acc = 0;
        lim = 64'sd90 << AngFrac;
        if (num == 0) return 0;
        if (den == 0) return lim;
        for (int i = 0; i < Stages && i < TableLen; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0) begin
                cx = cx + ys; cy = cy - xs; acc += steps[i];
            end else begin
                cx = cx - ys; cy = cy + xs; acc -= steps[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > lim) acc = lim;
        return acc;
    endfunction

    function automatic longint signed_tilt(input longint c, input longint unsigned a,
                                           input longint unsigned b);
        longint deg;
        longint unsigned mag;
        mag = (c < 0) ? -c : c;
        deg = cordic_angle(hypot_fix(a, b), mag << MagFrac) >>> AngFrac;
        return (c < 0) ? -deg : deg;
    endfunction

    function automatic att_out_t tilt_angles(input att_in_t smp);
        longint x, y, z, th, tz;
        longint unsigned ax, ay, az;
        att_out_t r;
        x = smp.accel_x;
        y = smp.accel_y;
        z = smp.accel_z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        th = cordic_angle(az << MagFrac, hypot_fix(ax, ay));
        if (z >= 0) tz = th >>> AngFrac;
        else tz = ((64'sd180 << AngFrac) - th) >>> AngFrac;
        r.tilt_x_deg = 8'(signed_tilt(x, ay, az));
        r.tilt_y_deg = 8'(signed_tilt(y, ax, az));
        r.tilt_z_deg = 8'(tz);
        return r;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 7)) - 16'd3;
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input att_in_t smp, input att_out_t angles);
        while (!no_gaps && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        angle_queue.push_back(angles);
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        att_in_t smp;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i])
            send_sample(dir_rows[i].sample, dir_rows[i].known ? dir_rows[i].angles
                                                              : tilt_angles(dir_rows[i].sample));
        for (int n = 0; n < NumRandom; n++) begin
            no_gaps = (n >= 400 && n < 700);
            if (n == 900) hold_req = 1'b1;
            smp.accel_x = rand_axis();
            smp.accel_y = rand_axis();
            smp.accel_z = rand_axis();
            send_sample(smp, tilt_angles(smp));
        end
        s_valid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge aclk);
        repeat (Latency + 5) @(posedge aclk);
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req && hold_cnt < HoldCycles) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_ready <= no_gaps || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge aclk) begin
        att_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (angle_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, m_data);
            end else begin
                want = angle_queue.pop_front();
                if (m_data.tilt_x_deg !== want.tilt_x_deg) begin
                    errors++;
                    $display("%0t: tilt_x_deg expected %0d actual %0d", $time,
                             want.tilt_x_deg, m_data.tilt_x_deg);
                end
                if (m_data.tilt_y_deg !== want.tilt_y_deg) begin
                    errors++;
                    $display("%0t: tilt_y_deg expected %0d actual %0d", $time,
                             want.tilt_y_deg, m_data.tilt_y_deg);
                end
                if (m_data.tilt_z_deg !== want.tilt_z_deg) begin
                    errors++;
                    $display("%0t: tilt_z_deg expected %0d actual %0d", $time,
                             want.tilt_z_deg, m_data.tilt_z_deg);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge aclk);
        while (!stim_done && idle_cycles < WdogLimit) @(posedge aclk);
        if (stim_done && angle_queue.size() == 0 && errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (!stim_done || angle_queue.size() != 0)
                $display("%0t: %0d results still expected", $time, angle_queue.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
